@@ hw/rtl/pcpf_pkg.sv @@
package pcpf_pkg;

    // Input sample width and sine table size.
    localparam int ADC_BITS          = 12;
    localparam int SINE_TABLE_POINTS = 1024;
    localparam int SINE_BITS         = $clog2(SINE_TABLE_POINTS);

    // Offset registers are fixed at 12 bits; the difference must hold either width.
    localparam int OFFSET_BITS = 12;
    localparam int DIFF_W      = ((ADC_BITS > OFFSET_BITS) ? ADC_BITS : OFFSET_BITS) + 1;

    // Shared multiplier operand and accumulator widths.
    localparam int MUL_A_W = 28;
    localparam int MUL_B_W = 26;
    localparam int ACC_W   = 56;
    localparam int VAL_W   = 24;

    localparam int POLY_A        = 51472;
    localparam int POLY_B        = 21024;
    localparam int POLY_C        = 2320;
    localparam int INV_SQRT3_Q16 = 37837;
    // floor(2^26 / 3), used to divide by three with one correction step.
    localparam int RECIP3        = 22369621;
    localparam int RECIP3_SHIFT  = 26;

    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef logic signed [VAL_W-1:0] val_t;

    typedef enum logic [2:0] {
        CFG_GAIN      = 3'd0,
        CFG_OFFSET_A  = 3'd1,
        CFG_OFFSET_B  = 3'd2,
        CFG_OFFSET_C  = 3'd3,
        CFG_SHUNT     = 3'd4,
        CFG_SMOOTHING = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [23:0]            current_gain;
        logic [OFFSET_BITS-1:0] offset_a;
        logic [OFFSET_BITS-1:0] offset_b;
        logic [OFFSET_BITS-1:0] offset_c;
        logic                   three_shunt;
        logic [15:0]            smoothing;
    } cfg_t;

    // Control of one multiply-accumulate request.
    typedef struct packed {
        logic        en;
        logic        keep;
        logic [15:0] rnd;
    } mac_op_t;

    function automatic val_t sat24(input logic signed [ACC_W-1:0] v);
        if (v > ACC_W'(VAL_MAX))
        begin
            return VAL_MAX;
        end
        else if (v < ACC_W'(VAL_MIN))
        begin
            return VAL_MIN;
        end
        return v[VAL_W-1:0];
    endfunction

endpackage

@@ hw/rtl/pcpf_mac.sv @@
module pcpf_mac (
    input  logic                                  clk,
    input  pcpf_pkg::mac_op_t                     op,
    input  logic signed [pcpf_pkg::MUL_A_W-1:0]   a,
    input  logic signed [pcpf_pkg::MUL_B_W-1:0]   b,
    output logic signed [pcpf_pkg::ACC_W-1:0]     acc
);
    import pcpf_pkg::*;

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] base;

    // A fresh request starts from the rounding constant, a kept one adds on.
    always_comb
    begin
        base     = op.keep ? acc_reg : ACC_W'(signed'({1'b0, op.rnd}));
        acc_next = base + ACC_W'(a * b);
    end

    always_ff @(posedge clk)
    begin
        if (op.en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

@@ hw/rtl/pcpf_cfg.sv @@
module pcpf_cfg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [2:0]       wr_index,
    input  logic [23:0]      wr_data,
    output pcpf_pkg::cfg_t   cfg
);
    import pcpf_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                CFG_GAIN:      cfg_next.current_gain = wr_data;
                CFG_OFFSET_A:  cfg_next.offset_a     = wr_data[OFFSET_BITS-1:0];
                CFG_OFFSET_B:  cfg_next.offset_b     = wr_data[OFFSET_BITS-1:0];
                CFG_OFFSET_C:  cfg_next.offset_c     = wr_data[OFFSET_BITS-1:0];
                CFG_SHUNT:     cfg_next.three_shunt  = wr_data[0];
                CFG_SMOOTHING: cfg_next.smoothing    = wr_data[15:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.current_gain <= '0;
            cfg_reg.offset_a     <= OFFSET_BITS'(2048);
            cfg_reg.offset_b     <= OFFSET_BITS'(2048);
            cfg_reg.offset_c     <= OFFSET_BITS'(2048);
            cfg_reg.three_shunt  <= 1'b0;
            cfg_reg.smoothing    <= 16'd6554;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hw/rtl/phase_current_clarke_park_filter.sv @@
// Channel   Direction  Handshake             Content
// cfg       in         cfg_valid/cfg_ready   register index and write data
// input     in         in_valid/in_stall     three ADC counts and rotor angle
// output    out        out_valid/out_stall   seven filtered currents, Q11.12
//
// Each request runs its steps on the single shared multiply-accumulate
// unit and then a flush state that loads the output register; the flush
// stretches while an earlier result is still waiting there. The block
// returns to idle with the load, so a new request is accepted only once
// the last one has been loaded into the output register.
// The input is stalled while a request is being worked on; a finished
// result waits in the output register, and a new request may be accepted
// while it does. Reset clears the filter memories and the control state.
module phase_current_clarke_park_filter (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [2:0]                           cfg_index,
    input  logic [23:0]                          cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [pcpf_pkg::ADC_BITS-1:0]        sample_a,
    input  logic [pcpf_pkg::ADC_BITS-1:0]        sample_b,
    input  logic [pcpf_pkg::ADC_BITS-1:0]        sample_c,
    input  logic [15:0]                          rotor_angle,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [23:0]                   amps_a,
    output logic signed [23:0]                   amps_b,
    output logic signed [23:0]                   amps_c,
    output logic signed [23:0]                   amps_alpha,
    output logic signed [23:0]                   amps_beta,
    output logic signed [23:0]                   amps_direct,
    output logic signed [23:0]                   amps_quadrature
);
    import pcpf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;

    localparam logic [4:0] STEP_LAST = 5'd24;

    // Configuration registers.
    cfg_t cfg;

    assign cfg_ready = 1'b1;

    pcpf_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Shared multiply-accumulate unit; its result is registered and available
    // in the cycle after the operands are presented.
    mac_op_t                   mac_op;
    logic signed [MUL_A_W-1:0] mac_a;
    logic signed [MUL_B_W-1:0] mac_b;
    logic signed [ACC_W-1:0]   acc;

    pcpf_mac u_mac (
        .clk (clk),
        .op  (mac_op),
        .a   (mac_a),
        .b   (mac_b),
        .acc (acc)
    );

    state_t state_reg, state_next;
    logic [4:0] step_reg, step_next;

    logic [ADC_BITS-1:0]  sa_reg, sa_next;
    logic [ADC_BITS-1:0]  sb_reg, sb_next;
    logic [ADC_BITS-1:0]  sc_reg, sc_next;
    logic [SINE_BITS-1:0] sidx_reg, sidx_next;

    val_t ia_reg, ia_next;
    val_t ib_reg, ib_next;
    val_t ic_reg, ic_next;
    val_t alpha_reg, alpha_next;
    val_t beta_reg, beta_next;
    val_t d_reg, d_next;
    val_t q_reg, q_next;

    logic [16:0]               z2_reg, z2_next;
    logic signed [17:0]        sn_reg, sn_next;
    logic signed [17:0]        cs_reg, cs_next;
    logic signed [MUL_A_W-1:0] qe_reg, qe_next;

    val_t sm_reg [7];
    val_t sm_next [7];

    logic out_valid_reg, out_valid_next;
    val_t out_reg [7];
    logic out_load;

    // Sine and cosine table positions.
    logic [SINE_BITS-1:0] cidx;
    logic [1:0]           quad_s;
    logic [1:0]           quad_c;
    logic [16:0]          z_s;
    logic [16:0]          z_c;

    // Intermediate arithmetic.
    logic signed [DIFF_W-1:0]  diff_a, diff_b, diff_c;
    logic signed [25:0]        sum_ab;
    logic signed [24:0]        diff_bc;
    logic signed [MUL_A_W-1:0] div_m;
    logic signed [MUL_A_W:0]   div_r;
    logic [16:0]               z2_new;
    logic [16:0]               t_new;
    logic [16:0]               s_new;
    logic                      sel_cos;
    logic [1:0]                quad_cur;
    logic [16:0]               z_cur;
    logic [MUL_B_W-1:0]        k_op;

    // Position within the quadrant in Q15, folded for odd quadrants.
    function automatic logic [16:0] quad_pos(input logic [SINE_BITS-1:0] idx);
        logic [16:0] z;
        z = 17'({idx[SINE_BITS-3:0], {(16 - SINE_BITS){1'b0}}}) << 1;
        if (idx[SINE_BITS-2])
        begin
            z = 17'd32768 - z;
        end
        return z;
    endfunction

    function automatic val_t filt(input val_t prev, input logic signed [ACC_W-1:0] a);
        return sat24(ACC_W'(prev) + (a >>> 16));
    endfunction

    function automatic logic signed [MUL_A_W-1:0] filt_in(input val_t x, input val_t prev);
        logic signed [24:0] d;
        d = 25'(x) - 25'(prev);
        return MUL_A_W'(d);
    endfunction

    always_comb
    begin
        cidx   = sidx_reg + SINE_BITS'(SINE_TABLE_POINTS / 4);
        quad_s = sidx_reg[SINE_BITS-1 -: 2];
        quad_c = cidx[SINE_BITS-1 -: 2];
        z_s    = quad_pos(sidx_reg);
        z_c    = quad_pos(cidx);

        diff_a  = DIFF_W'(signed'({1'b0, cfg.offset_a})) - DIFF_W'(signed'({1'b0, sa_reg}));
        diff_b  = DIFF_W'(signed'({1'b0, cfg.offset_b})) - DIFF_W'(signed'({1'b0, sb_reg}));
        diff_c  = DIFF_W'(signed'({1'b0, cfg.offset_c})) - DIFF_W'(signed'({1'b0, sc_reg}));
        sum_ab  = 26'(ia_reg) + 26'(ib_reg);
        diff_bc = 25'(ib_reg) - 25'(ic_reg);
        // alpha = floor((2a - b - c + 1) / 3), which equals the rounded (2a-b-c)/3.
        div_m   = (MUL_A_W'(ia_reg) <<< 1) - MUL_A_W'(ib_reg) - MUL_A_W'(ic_reg)
                  + MUL_A_W'(1);
        div_r   = (MUL_A_W+1)'(div_m) - (MUL_A_W+1)'(qe_reg) - ((MUL_A_W+1)'(qe_reg) <<< 1);

        z2_new = 17'(acc >>> 15);
        t_new  = 17'(POLY_B) - 17'(acc >>> 15);
        s_new  = 17'(acc >>> 15);
        k_op   = MUL_B_W'({1'b0, cfg.smoothing});

        // The polynomial is run twice: steps 3 to 7 for sine, 7 to 11 for cosine.
        sel_cos  = (step_reg >= 5'd7);
        quad_cur = sel_cos ? quad_c : quad_s;
        z_cur    = sel_cos ? z_c : z_s;
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        sa_next        = sa_reg;
        sb_next        = sb_reg;
        sc_next        = sc_reg;
        sidx_next      = sidx_reg;
        ia_next        = ia_reg;
        ib_next        = ib_reg;
        ic_next        = ic_reg;
        alpha_next     = alpha_reg;
        beta_next      = beta_reg;
        d_next         = d_reg;
        q_next         = q_reg;
        z2_next        = z2_reg;
        sn_next        = sn_reg;
        cs_next        = cs_reg;
        qe_next        = qe_reg;
        for (int i = 0; i < 7; i++)
        begin
            sm_next[i] = sm_reg[i];
        end
        out_load       = 1'b0;
        out_valid_next = out_valid_reg && out_stall;

        mac_op.en   = 1'b0;
        mac_op.keep = 1'b0;
        mac_op.rnd  = '0;
        mac_a       = '0;
        mac_b       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    sa_next    = sample_a;
                    sb_next    = sample_b;
                    sc_next    = sample_c;
                    sidx_next  = rotor_angle[15 -: SINE_BITS];
                    step_next  = '0;
                    state_next = ST_RUN;
                end
            end

            ST_RUN:
            begin
                mac_op.en = 1'b1;
                step_next = step_reg + 5'd1;
                case (step_reg)
                    5'd0:
                    begin
                        mac_a      = MUL_A_W'(diff_a);
                        mac_b      = MUL_B_W'(signed'({1'b0, cfg.current_gain}));
                        mac_op.rnd = 16'd2048;
                    end
                    5'd1:
                    begin
                        ia_next    = sat24(acc >>> 12);
                        mac_a      = MUL_A_W'(diff_b);
                        mac_b      = MUL_B_W'(signed'({1'b0, cfg.current_gain}));
                        mac_op.rnd = 16'd2048;
                    end
                    5'd2:
                    begin
                        ib_next    = sat24(acc >>> 12);
                        mac_a      = MUL_A_W'(diff_c);
                        mac_b      = MUL_B_W'(signed'({1'b0, cfg.current_gain}));
                        mac_op.rnd = 16'd2048;
                    end
                    5'd3:
                    begin
                        // With two shunts phase C is rebuilt from A and B.
                        ic_next = cfg.three_shunt ? sat24(acc >>> 12)
                                                  : sat24(ACC_W'(-sum_ab));
                        mac_a   = MUL_A_W'(signed'(z_s));
                        mac_b   = MUL_B_W'(signed'(z_s));
                    end
                    5'd4, 5'd8:
                    begin
                        z2_next = z2_new;
                        mac_a   = MUL_A_W'(signed'(z2_new));
                        mac_b   = MUL_B_W'(POLY_C);
                    end
                    5'd5, 5'd9:
                    begin
                        mac_a  = MUL_A_W'(signed'(t_new));
                        mac_b  = MUL_B_W'(signed'(z2_reg));
                    end
                    5'd6, 5'd10:
                    begin
                        mac_a  = MUL_A_W'(signed'(17'(POLY_A) - 17'(acc >>> 15)));
                        mac_b  = MUL_B_W'(signed'(z_cur));
                    end
                    5'd7:
                    begin
                        sn_next = quad_s[1] ? -18'(signed'(s_new)) : 18'(signed'(s_new));
                        mac_a   = MUL_A_W'(signed'(z_c));
                        mac_b   = MUL_B_W'(signed'(z_c));
                    end
                    5'd11:
                    begin
                        cs_next    = quad_cur[1] ? -18'(signed'(s_new)) : 18'(signed'(s_new));
                        mac_a      = MUL_A_W'(diff_bc);
                        mac_b      = MUL_B_W'(INV_SQRT3_Q16);
                        mac_op.rnd = 16'd32768;
                    end
                    5'd12:
                    begin
                        beta_next = sat24(acc >>> 16);
                        mac_a     = div_m;
                        mac_b     = MUL_B_W'(RECIP3);
                    end
                    5'd13:
                    begin
                        // The estimate is the true quotient or one below it.
                        qe_next    = MUL_A_W'(acc >>> RECIP3_SHIFT);
                        mac_a      = filt_in(ia_reg, sm_reg[0]);
                        mac_b      = k_op;
                        mac_op.rnd = 16'd32768;
                    end
                    5'd14:
                    begin
                        sm_next[0] = filt(sm_reg[0], acc);
                        alpha_next = sat24(ACC_W'(qe_reg)
                                           + ACC_W'(signed'({1'b0, div_r >= 3})));
                        mac_a      = filt_in(ib_reg, sm_reg[1]);
                        mac_b      = k_op;
                        mac_op.rnd = 16'd32768;
                    end
                    5'd15:
                    begin
                        sm_next[1] = filt(sm_reg[1], acc);
                        mac_a      = filt_in(ic_reg, sm_reg[2]);
                        mac_b      = k_op;
                        mac_op.rnd = 16'd32768;
                    end
                    5'd16:
                    begin
                        sm_next[2] = filt(sm_reg[2], acc);
                        mac_a      = MUL_A_W'(alpha_reg);
                        mac_b      = MUL_B_W'(cs_reg);
                        mac_op.rnd = 16'd16384;
                    end
                    5'd17:
                    begin
                        mac_a       = MUL_A_W'(beta_reg);
                        mac_b       = MUL_B_W'(sn_reg);
                        mac_op.keep = 1'b1;
                    end
                    5'd18:
                    begin
                        d_next     = sat24(acc >>> 15);
                        mac_a      = MUL_A_W'(beta_reg);
                        mac_b      = MUL_B_W'(cs_reg);
                        mac_op.rnd = 16'd16384;
                    end
                    5'd19:
                    begin
                        mac_a       = MUL_A_W'(alpha_reg);
                        mac_b       = -MUL_B_W'(sn_reg);
                        mac_op.keep = 1'b1;
                    end
                    5'd20:
                    begin
                        q_next     = sat24(acc >>> 15);
                        mac_a      = filt_in(alpha_reg, sm_reg[3]);
                        mac_b      = k_op;
                        mac_op.rnd = 16'd32768;
                    end
                    5'd21:
                    begin
                        sm_next[3] = filt(sm_reg[3], acc);
                        mac_a      = filt_in(beta_reg, sm_reg[4]);
                        mac_b      = k_op;
                        mac_op.rnd = 16'd32768;
                    end
                    5'd22:
                    begin
                        sm_next[4] = filt(sm_reg[4], acc);
                        mac_a      = filt_in(d_reg, sm_reg[5]);
                        mac_b      = k_op;
                        mac_op.rnd = 16'd32768;
                    end
                    5'd23:
                    begin
                        sm_next[5] = filt(sm_reg[5], acc);
                        mac_a      = filt_in(q_reg, sm_reg[6]);
                        mac_b      = k_op;
                        mac_op.rnd = 16'd32768;
                    end
                    default:
                    begin
                        mac_op.en  = 1'b0;
                        sm_next[6] = filt(sm_reg[6], acc);
                        step_next  = step_reg;
                        state_next = ST_FLUSH;
                    end
                endcase
            end

            ST_FLUSH:
            begin
                // Wait until the previous result has been taken.
                if (!out_valid_reg || !out_stall)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 7; i++)
            begin
                sm_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < 7; i++)
            begin
                sm_reg[i] <= sm_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sa_reg    <= sa_next;
        sb_reg    <= sb_next;
        sc_reg    <= sc_next;
        sidx_reg  <= sidx_next;
        ia_reg    <= ia_next;
        ib_reg    <= ib_next;
        ic_reg    <= ic_next;
        alpha_reg <= alpha_next;
        beta_reg  <= beta_next;
        d_reg     <= d_next;
        q_reg     <= q_next;
        z2_reg    <= z2_next;
        sn_reg    <= sn_next;
        cs_reg    <= cs_next;
        qe_reg    <= qe_next;
        if (out_load)
        begin
            for (int i = 0; i < 7; i++)
            begin
                out_reg[i] <= sm_reg[i];
            end
        end
    end

    assign in_stall        = (state_reg != ST_IDLE);
    assign out_valid       = out_valid_reg;
    assign amps_a          = out_reg[0];
    assign amps_b          = out_reg[1];
    assign amps_c          = out_reg[2];
    assign amps_alpha      = out_reg[3];
    assign amps_beta       = out_reg[4];
    assign amps_direct     = out_reg[5];
    assign amps_quadrature = out_reg[6];

    // An accepted request always starts the sequence at its first step.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == ST_RUN && step_reg == 5'd0)
        else $error("request accepted without starting the sequence");

    // The step counter never runs past the last step.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> step_reg <= STEP_LAST)
        else $error("step counter overran");

    // A new result appears only on leaving the flush state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == ST_FLUSH)
        else $error("result presented outside the flush state");

    // A waiting result is never overwritten by the next one.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(amps_direct) && $stable(amps_a))
        else $error("waiting result overwritten");

endmodule
